/* design/hnm_pkg.sv */
// hnm_pkg: shared types and constants of the heightfield normal generator
// holds default sizes, register indexes, controller states and the
// command / status structs between controller and datapath; no dependencies
package hnm_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int HEIGHT_BITS_DEF = 24;
  localparam int NORMAL_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GSCALE  = 3'd4;

  localparam int WORLD_W = 23;
  localparam logic [WORLD_W-1:0] WORLD_MAX = 23'h7FFFFF;

  // component selects of the shared square / divide steps
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_NORM,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_OUT
  } hnm_state_t;

  typedef struct packed {
    logic       accept;
    logic       read;
    logic       grad;
    logic       shift;
    logic       square;
    logic [1:0] sq_sel;
    logic       root_step;
    logic       root_first;
    logic [4:0] root_idx;
    logic       div_step;
    logic       div_first;
    logic       div_last;
    logic [1:0] div_sel;
    logic [4:0] div_k;
    logic       load_out;
  } hnm_cmd_t;

  typedef struct packed {
    logic vtx_valid;
    logic norm_big;
    logic out_busy;
  } hnm_stat_t;

endpackage

/* design/hnm_ram.sv */
// hnm_ram: generic single-write, single-read memory with registered read
// used for the two line stores; no dependencies
module hnm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/hnm_ctrl.sv */
// hnm_ctrl: sequencing state machine of the normal generator
// steps one request through read, gradient, scaling, squares, root and divides
// depends on hnm_pkg
module hnm_ctrl #(
  parameter int NORMAL_BITS = hnm_pkg::NORMAL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  hnm_pkg::hnm_stat_t status,
  output hnm_pkg::hnm_cmd_t  cmd
);
  import hnm_pkg::*;

  localparam logic [4:0] DIV_LAST  = 5'(NORMAL_BITS - 1);
  localparam logic [4:0] ROOT_LAST = 5'd31;
  localparam logic [4:0] SQ_LAST   = 5'd2;

  hnm_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sel_r   <= SEL_X;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = status.vtx_valid ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (!status.norm_big) begin
          state_nxt = ST_SQ;
          cnt_nxt   = '0;
        end
      end
      ST_SQ: begin
        if (cnt_r == SQ_LAST) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_ROOT: begin
        if (cnt_r == ROOT_LAST) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
          sel_nxt   = SEL_X;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          cnt_nxt = '0;
          if (sel_r == SEL_Z) begin
            state_nxt = ST_OUT;
          end else begin
            sel_nxt = sel_r + 2'd1;
          end
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_OUT: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    cmd.sq_sel   = cnt_r[1:0];
    cmd.root_idx = cnt_r;
    cmd.div_sel  = sel_r;
    cmd.div_k    = DIV_LAST - cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_READ: cmd.read = 1'b1;
      ST_GRAD: cmd.grad = 1'b1;
      ST_NORM: cmd.shift = status.norm_big;
      ST_SQ:   cmd.square = 1'b1;
      ST_ROOT: begin
        cmd.root_step  = 1'b1;
        cmd.root_first = (cnt_r == '0);
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        cmd.div_last  = (cnt_r == DIV_LAST);
      end
      ST_OUT: cmd.load_out = !status.out_busy;
      default: ;
    endcase
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_READ))
    else $error("accepted request not followed by line store read");

  a_skip_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && !status.vtx_valid) |=> (state_r == ST_IDLE))
    else $error("no-vertex request did not return to idle");

  a_scaled_before_square: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> !status.norm_big)
    else $error("squaring an unscaled gradient");

  a_root_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && cnt_r == ROOT_LAST) |=> (state_r == ST_DIV && cnt_r == '0))
    else $error("root did not hand over to the divider");

endmodule

/* design/hnm_dp.sv */
// hnm_dp: datapath of the normal generator: registers, line stores, 3x3 window,
// counters, running extremes, gradient, bit-serial root and divider, output register
// depends on hnm_pkg and hnm_ram
module hnm_dp #(
  parameter int MAX_COLUMNS = hnm_pkg::MAX_COLUMNS_DEF,
  parameter int HEIGHT_BITS = hnm_pkg::HEIGHT_BITS_DEF,
  parameter int NORMAL_BITS = hnm_pkg::NORMAL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hnm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hnm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic signed [HEIGHT_BITS-1:0]       in_height,
  input  logic                                in_flush,
  input  hnm_pkg::hnm_cmd_t                   cmd,
  output hnm_pkg::hnm_stat_t                  status,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [hnm_pkg::WORLD_W-1:0]         world_x,
  output logic [hnm_pkg::WORLD_W-1:0]         world_z,
  output logic signed [HEIGHT_BITS-1:0]       vertex_height,
  output logic signed [NORMAL_BITS-1:0]       normal_x,
  output logic [NORMAL_BITS-2:0]              normal_y,
  output logic signed [NORMAL_BITS-1:0]       normal_z,
  output logic signed [HEIGHT_BITS-1:0]       lowest_height,
  output logic signed [HEIGHT_BITS-1:0]       highest_height,
  output logic                                final_vertex
);
  import hnm_pkg::*;

  localparam int HB   = HEIGHT_BITS;
  localparam int NB   = NORMAL_BITS;
  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int CLW  = $clog2(MAX_COLUMNS + 1);
  localparam int NCW  = (CLW > 11) ? CLW : 11;
  localparam int MW   = (HB + 17 > 31) ? HB + 17 : 31;
  localparam int GW   = HB + 18;
  localparam int DW   = 31 + NB;
  localparam int SW   = 63;
  localparam int WXW  = (CW + 13 > WORLD_W) ? CW + 13 : WORLD_W;
  localparam logic signed [HB-1:0] H_MAX = {1'b0, {(HB-1){1'b1}}};
  localparam logic signed [HB-1:0] H_MIN = {1'b1, {(HB-1){1'b0}}};
  localparam logic [NB-2:0] N_MAX = '1;

  // configuration registers
  logic [10:0] cols_cfg_r;
  logic [15:0] rows_cfg_r, gscale_r;
  logic [6:0]  stride_r, size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= 11'd1024;
      rows_cfg_r <= 16'd1024;
      stride_r   <= 7'd1;
      size_r     <= 7'd8;
      gscale_r   <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS: cols_cfg_r <= cfg_wdata[10:0];
        CFG_ROWS:    rows_cfg_r <= cfg_wdata;
        CFG_STRIDE:  stride_r   <= cfg_wdata[6:0];
        CFG_SQUARE:  size_r     <= cfg_wdata[6:0];
        CFG_GSCALE:  gscale_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [NCW-1:0] cols_ext, cols;
  logic [16:0]    rows;
  logic [6:0]     stride_c, size_c;
  logic [12:0]    unit;

  always_comb begin
    cols_ext = NCW'(cols_cfg_r);
    if (cols_ext < NCW'(2))                cols = NCW'(2);
    else if (cols_ext > NCW'(MAX_COLUMNS)) cols = NCW'(MAX_COLUMNS);
    else                                   cols = cols_ext;
    rows     = (rows_cfg_r < 16'd2) ? 17'd2 : {1'b0, rows_cfg_r};
    stride_c = (stride_r == 7'd0) ? 7'd1 : ((stride_r > 7'd64) ? 7'd64 : stride_r);
    size_c   = (size_r == 7'd0) ? 7'd1 : ((size_r > 7'd64) ? 7'd64 : size_r);
    unit     = 13'(stride_c) * 13'(size_c);
  end

  // input request and line stores
  logic signed [HB-1:0] h_r;
  logic [CW-1:0]        col_r;
  logic [16:0]          row_r;
  logic [HB-1:0]        prev_q, old_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) h_r <= in_flush ? '0 : in_height;
  end

  hnm_ram #(.WIDTH(HB), .DEPTH(MAX_COLUMNS)) u_prev_row (
    .clk(clk), .we(cmd.read), .waddr(col_r), .wdata(h_r),
    .raddr(col_r), .rdata(prev_q)
  );

  hnm_ram #(.WIDTH(HB), .DEPTH(MAX_COLUMNS)) u_old_row (
    .clk(clk), .we(cmd.read), .waddr(col_r), .wdata(prev_q),
    .raddr(col_r), .rdata(old_q)
  );

  // window: column 2 is the newest, column 1 the center column
  logic signed [HB-1:0] w01_r, w11_r, w21_r, w02_r, w12_r, w22_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {w01_r, w11_r, w21_r, w02_r, w12_r, w22_r} <= '0;
    end else if (cmd.read) begin
      w01_r <= w02_r;
      w11_r <= w12_r;
      w21_r <= w22_r;
      w02_r <= old_q;
      w12_r <= prev_q;
      w22_r <= h_r;
    end
  end

  // vertex position from the counters before their update
  logic           pre_valid, vtx_valid, last;
  logic [16:0]    vr;
  logic [NCW-1:0] vc;
  logic signed [HB-1:0] c, lf_s, rt_s, up_s, dn_s;
  logic signed [HB:0]   dx, dz;
  logic signed [HB-1:0] mn_upd, mx_upd, mn_r, mx_r;
  logic [NCW:0]   col_inc;
  logic [17:0]    row_inc, row_step;
  logic           row_over;

  always_comb begin
    pre_valid = 1'b0;
    vr        = '0;
    vc        = '0;
    if (col_r != '0 && row_r != '0) begin
      pre_valid = 1'b1;
      vr        = row_r - 17'd1;
      vc        = NCW'(col_r) - NCW'(1);
    end else if (col_r == '0 && row_r >= 17'd2) begin
      pre_valid = 1'b1;
      vr        = row_r - 17'd2;
      vc        = cols - NCW'(1);
    end
    vtx_valid = pre_valid && (vr < rows) && (vc < cols);
    last      = vtx_valid && (vr == rows - 17'd1) && (vc == cols - NCW'(1));

    // neighbors after the window shift, clamped at the grid edges
    c    = w12_r;
    lf_s = (vc == '0) ? c : w12_r;
    lf_s = (vc == '0) ? c : w11_r;
    rt_s = (vc == cols - NCW'(1)) ? c : $signed(prev_q);
    up_s = (vr == '0) ? c : w02_r;
    dn_s = (vr == rows - 17'd1) ? c : w22_r;
    dx   = (HB+1)'(rt_s) - (HB+1)'(lf_s);
    dz   = (HB+1)'(dn_s) - (HB+1)'(up_s);

    mn_upd   = (c < mn_r) ? c : mn_r;
    mx_upd   = (c > mx_r) ? c : mx_r;
    col_inc  = (NCW+1)'(col_r) + (NCW+1)'(1);
    row_inc  = 18'(row_r) + 18'd1;
    // a row counter past the grid wraps on every request, not only at a row end
    row_step = (col_inc >= (NCW+1)'(cols)) ? row_inc : 18'(row_r);
    row_over = row_step > 18'(rows) + 18'd1;
  end

  logic signed [HB-1:0] c_r, min_hold_r, max_hold_r;
  logic signed [HB:0]   dx_r, dz_r;
  logic [15:0]          vr_r;
  logic [CW-1:0]        vc_r;
  logic                 last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      mn_r  <= H_MAX;
      mx_r  <= H_MIN;
    end else if (cmd.read) begin
      if (last) begin
        col_r <= '0;
        row_r <= '0;
        mn_r  <= H_MAX;
        mx_r  <= H_MIN;
      end else begin
        if (vtx_valid) begin
          mn_r <= mn_upd;
          mx_r <= mx_upd;
        end
        if (row_over) begin
          col_r <= '0;
          row_r <= '0;
          mn_r  <= H_MAX;
          mx_r  <= H_MIN;
        end else if (col_inc >= (NCW+1)'(cols)) begin
          col_r <= '0;
          row_r <= row_step[16:0];
        end else begin
          col_r <= col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      c_r        <= c;
      dx_r       <= dx;
      dz_r       <= dz;
      vr_r       <= vr[15:0];
      vc_r       <= vc[CW-1:0];
      last_r     <= last;
      min_hold_r <= mn_upd;
      max_hold_r <= mx_upd;
    end
  end

  // gradient scaling and world position
  logic signed [GW-1:0] gx, gz;
  logic [GW-1:0]        gx_abs, gz_abs;
  logic [MW-1:0]        ax_n, az_n, one_n, m_n;
  logic [WXW-1:0]       wx_full;
  logic [28:0]          wz_full;

  always_comb begin
    gx      = dx_r * $signed({1'b0, gscale_r});
    gz      = dz_r * $signed({1'b0, gscale_r});
    gx_abs  = gx[GW-1] ? GW'(-gx) : GW'(gx);
    gz_abs  = gz[GW-1] ? GW'(-gz) : GW'(gz);
    ax_n    = MW'(gx_abs);
    az_n    = MW'(gz_abs);
    one_n   = MW'(25'h100_0000);
    m_n     = (ax_n > az_n) ? ax_n : az_n;
    m_n     = (one_n > m_n) ? one_n : m_n;
    wx_full = WXW'(vc_r) * WXW'(unit);
    wz_full = 29'(vr_r) * 29'(unit);
  end

  logic [MW-1:0]        ax_r, az_r, one_r, m_r;
  logic                 gx_pos_r, gz_pos_r;
  logic [WORLD_W-1:0]   wx_r, wz_r;
  logic [61:0]          sum_r;
  logic [29:0]          sq_in;
  logic [59:0]          sq;

  always_comb begin
    case (cmd.sq_sel)
      SEL_X:   sq_in = ax_r[29:0];
      SEL_Y:   sq_in = one_r[29:0];
      default: sq_in = az_r[29:0];
    endcase
    sq = 60'(sq_in) * 60'(sq_in);
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      ax_r     <= ax_n;
      az_r     <= az_n;
      one_r    <= one_n;
      m_r      <= m_n;
      gx_pos_r <= !gx[GW-1] && (gx != '0);
      gz_pos_r <= !gz[GW-1] && (gz != '0);
      wx_r     <= (wx_full > WXW'(WORLD_MAX)) ? WORLD_MAX : wx_full[WORLD_W-1:0];
      wz_r     <= (wz_full > 29'(WORLD_MAX)) ? WORLD_MAX : wz_full[WORLD_W-1:0];
      sum_r    <= '0;
    end else if (cmd.shift) begin
      ax_r  <= ax_r >> 1;
      az_r  <= az_r >> 1;
      one_r <= one_r >> 1;
      m_r   <= m_r >> 1;
    end else if (cmd.square) begin
      sum_r <= sum_r + 62'(sq);
    end
  end

  // bit-serial integer square root, one result bit per step
  logic [SW-1:0] rem_r, root_r, rem_src, root_src, rbit, rtry;

  always_comb begin
    rem_src  = cmd.root_first ? SW'(sum_r) : rem_r;
    root_src = cmd.root_first ? '0 : root_r;
    rbit     = SW'(1) << (7'd62 - {cmd.root_idx, 1'b0});
    rtry     = root_src + rbit;
  end

  always_ff @(posedge clk) begin
    if (cmd.root_step) begin
      if (rem_src >= rtry) begin
        rem_r  <= rem_src - rtry;
        root_r <= (root_src >> 1) + rbit;
      end else begin
        rem_r  <= rem_src;
        root_r <= root_src >> 1;
      end
    end
  end

  // restoring divider, rounded quotient of v * 2^(NB-1) by the root
  logic [31:0]   rroot;
  logic [29:0]   dv;
  logic [DW-1:0] num, drem_src, dsub, drem_r;
  logic [NB-1:0] dq_src, dq_r, dq_nxt;
  logic [NB-2:0] qsat;
  logic          dfit;

  always_comb begin
    rroot = root_r[31:0];
    case (cmd.div_sel)
      SEL_X:   dv = ax_r[29:0];
      SEL_Y:   dv = one_r[29:0];
      default: dv = az_r[29:0];
    endcase
    num      = (DW'(dv) << (NB - 1)) + DW'(rroot >> 1);
    drem_src = cmd.div_first ? num : drem_r;
    dq_src   = cmd.div_first ? '0 : dq_r;
    dsub     = DW'(rroot) << cmd.div_k;
    dfit     = drem_src >= dsub;
    dq_nxt   = dfit ? (dq_src | (NB'(1) << cmd.div_k)) : dq_src;
    qsat     = (dq_nxt > NB'(N_MAX)) ? N_MAX : dq_nxt[NB-2:0];
  end

  logic [NB-2:0] mx_mag_r, my_mag_r, mz_mag_r;

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      drem_r <= dfit ? drem_src - dsub : drem_src;
      dq_r   <= dq_nxt;
      if (cmd.div_last) begin
        case (cmd.div_sel)
          SEL_X:   mx_mag_r <= qsat;
          SEL_Y:   my_mag_r <= qsat;
          default: mz_mag_r <= qsat;
        endcase
      end
    end
  end

  // output register
  logic out_valid_r;
  logic zero_len;
  logic signed [NB-1:0] nx_val, nz_val;

  always_comb begin
    zero_len = (rroot == '0);
    nx_val   = gx_pos_r ? -$signed({1'b0, mx_mag_r}) : $signed({1'b0, mx_mag_r});
    nz_val   = gz_pos_r ? -$signed({1'b0, mz_mag_r}) : $signed({1'b0, mz_mag_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      world_x        <= wx_r;
      world_z        <= wz_r;
      vertex_height  <= c_r;
      normal_x       <= zero_len ? '0 : nx_val;
      normal_y       <= zero_len ? N_MAX : my_mag_r;
      normal_z       <= zero_len ? '0 : nz_val;
      lowest_height  <= min_hold_r;
      highest_height <= max_hold_r;
      final_vertex   <= last_r;
    end
  end

  assign out_tvalid       = out_valid_r;
  assign status.vtx_valid = vtx_valid;
  assign status.norm_big  = |m_r[MW-1:30];
  assign status.out_busy  = out_valid_r && !out_tready;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_tready))
    else $error("result register overwritten while still held");

  a_extremes_order: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.read) && $past(vtx_valid) |-> (min_hold_r <= max_hold_r))
    else $error("running minimum above running maximum");

endmodule

/* design/heightfield_normal_generator_core.sv */
// heightfield_normal_generator_core: one request at a time, accepted in idle, then
// line store read, gradient, 0..10 scaling shifts at the default widths, 3 squares,
// 32 root steps and 3 x NORMAL_BITS divider steps; a no-vertex request returns to
// idle straight after the line store read
// result register frees the input side while a result waits
// synchronous active-low reset clears control, counters, window and extremes
module heightfield_normal_generator_core #(
  parameter int MAX_COLUMNS = hnm_pkg::MAX_COLUMNS_DEF,
  parameter int HEIGHT_BITS = hnm_pkg::HEIGHT_BITS_DEF,
  parameter int NORMAL_BITS = hnm_pkg::NORMAL_BITS_DEF,
  localparam int IN_W  = ((HEIGHT_BITS + 7) / 8) * 8,
  localparam int OUT_B = 2 * hnm_pkg::WORLD_W + 3 * HEIGHT_BITS + 3 * NORMAL_BITS - 1,
  localparam int OUT_W = ((OUT_B + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hnm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hnm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,   // sample_height
  input  logic                            in_tuser,   // flush_item
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // world_x, world_z, vertex_height, normal_x, normal_y, normal_z,
  // lowest_height, highest_height
  output logic [OUT_W-1:0]                out_tdata,
  output logic                            out_tlast   // final_vertex
);
  import hnm_pkg::*;

  hnm_cmd_t  cmd;
  hnm_stat_t status;

  logic [hnm_pkg::WORLD_W-1:0] world_x, world_z;
  logic signed [HEIGHT_BITS-1:0] vertex_height, lowest_height, highest_height;
  logic signed [NORMAL_BITS-1:0] normal_x, normal_z;
  logic [NORMAL_BITS-2:0]        normal_y;

  hnm_ctrl #(.NORMAL_BITS(NORMAL_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .status(status), .cmd(cmd)
  );

  hnm_dp #(
    .MAX_COLUMNS(MAX_COLUMNS), .HEIGHT_BITS(HEIGHT_BITS), .NORMAL_BITS(NORMAL_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_height($signed(in_tdata[HEIGHT_BITS-1:0])), .in_flush(in_tuser),
    .cmd(cmd), .status(status),
    .out_tready(out_tready), .out_tvalid(out_tvalid),
    .world_x(world_x), .world_z(world_z), .vertex_height(vertex_height),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .lowest_height(lowest_height), .highest_height(highest_height),
    .final_vertex(out_tlast)
  );

  assign out_tdata = OUT_W'({highest_height, lowest_height, normal_z, normal_y,
                             normal_x, vertex_height, world_z, world_x});

endmodule

/* dv/heightfield_normal_generator_core_tb.sv */
// testbench of heightfield_normal_generator_core: streams small height grids with flush tails,
// predicts each vertex normal, world position and running extremes, checks every result
// depends on hnm_pkg and the core rtl
`timescale 1ns / 100ps

module heightfield_normal_generator_core_tb;
  import hnm_pkg::*;

  localparam int COLS_MAX   = 1024;
  localparam int IN_W       = 24;
  localparam int OUT_W      = 168;
  localparam longint HMAX   = 8388607;
  localparam longint HMIN   = -8388608;
  localparam longint NMAX   = 32767;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [22:0] wx;
    logic [22:0] wz;
    logic [23:0] vh;
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
    logic [23:0] lo;
    logic [23:0] hi;
    logic        last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COLUMNS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;

  heightfield_normal_generator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of registers and state
  longint unsigned reg_cols = 1024, reg_rows = 1024, reg_stride = 1, reg_square = 8;
  longint unsigned reg_gscale = 4096;
  longint prev_row [COLS_MAX];
  longint older_row [COLS_MAX];
  longint win [3][3];
  longint unsigned col_pos, row_pos;
  longint run_min, run_max;

  vertex_t vertex_q[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  int sent = 0;

  function automatic longint unsigned clampu(longint unsigned v, longint unsigned lo,
                                             longint unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_part(longint unsigned v, longint unsigned r);
    longint unsigned q;
    q = ((v << 15) + r / 2) / r;
    return q > NMAX ? NMAX : longint'(q);
  endfunction

  task automatic unit_normal(input longint gx, input longint gz,
                             output longint nx, output longint ny, output longint nz);
    longint unsigned ax, az, one, m, sum, r;
    int s;
    ax = gx < 0 ? -gx : gx;
    az = gz < 0 ? -gz : gz;
    one = 64'd1 << 24;
    m = ax > az ? ax : az;
    if (one > m) m = one;
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    ax = ax >> s;
    az = az >> s;
    one = one >> s;
    sum = ax * ax + one * one + az * az;
    if (sum == 0) begin
      nx = 0; ny = NMAX; nz = 0;
    end else begin
      r = isqrt(sum);
      nx = gx > 0 ? -unit_part(ax, r) : unit_part(ax, r);
      nz = gz > 0 ? -unit_part(az, r) : unit_part(az, r);
      ny = unit_part(one, r);
    end
  endtask

  function automatic void clear_extremes();
    run_min = HMAX;
    run_max = HMIN;
  endfunction

  task automatic predict_vertex(input logic [IN_W-1:0] raw, input bit flush);
    longint unsigned cols, rows, span, vr, vc, wx, wz;
    longint h, top, mid, c, lf, rt, up, dn, nx, ny, nz;
    int idx;
    bit ok, last;
    vertex_t v;
    cols = clampu(reg_cols, 2, COLS_MAX);
    rows = clampu(reg_rows, 2, 65535);
    span = clampu(reg_stride, 1, 64) * clampu(reg_square, 1, 64);
    h = flush ? 0 : longint'($signed(raw));
    idx = col_pos < COLS_MAX ? int'(col_pos) : COLS_MAX - 1;
    top = older_row[idx];
    mid = prev_row[idx];
    older_row[idx] = mid;
    prev_row[idx] = h;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = h;
    ok = 0; vr = 0; vc = 0;
    if (col_pos >= 1 && row_pos >= 1) begin
      vr = row_pos - 1; vc = col_pos - 1; ok = 1;
    end else if (col_pos == 0 && row_pos >= 2) begin
      vr = row_pos - 2; vc = cols - 1; ok = 1;
    end
    if (ok && (vr >= rows || vc >= cols)) ok = 0;
    if (ok) begin
      c = win[1][1];
      // neighbours outside the grid fall back to the vertex itself
      lf = vc == 0 ? c : win[1][0];
      rt = vc == cols - 1 ? c : win[1][2];
      up = vr == 0 ? c : win[0][1];
      dn = vr == rows - 1 ? c : win[2][1];
      unit_normal((rt - lf) * longint'(reg_gscale), (dn - up) * longint'(reg_gscale),
                  nx, ny, nz);
      if (c < run_min) run_min = c;
      if (c > run_max) run_max = c;
      wx = vc * span;
      wz = vr * span;
      last = (vr == rows - 1) && (vc == cols - 1);
      v.wx = wx > 8388607 ? 23'h7FFFFF : wx[22:0];
      v.wz = wz > 8388607 ? 23'h7FFFFF : wz[22:0];
      v.vh = c[23:0];
      v.nx = nx[15:0];
      v.ny = ny[14:0];
      v.nz = nz[15:0];
      v.lo = run_min[23:0];
      v.hi = run_max[23:0];
      v.last = last;
      vertex_q = {vertex_q, v};
      if (last) begin
        col_pos = 0; row_pos = 0;
        clear_extremes();
        return;
      end
    end
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > rows + 1) begin
      col_pos = 0; row_pos = 0;
      clear_extremes();
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random holds, one long hold on request
  initial begin : sink
    int n;
    bit took;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        n = 3000;
        hold_req = 0;
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_tvalid && out_tready;
        @(posedge clk);
      end while (!took);
    end
  end

  task automatic report(input string fld, input longint unsigned want, input longint unsigned got);
    errors++;
    $display("%0t mismatch %s expected %h actual %h", $realtime, fld, want, got);
  endtask

  always @(negedge clk) begin
    vertex_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      a.wx = out_tdata[22:0];
      a.wz = out_tdata[45:23];
      a.vh = out_tdata[69:46];
      a.nx = out_tdata[85:70];
      a.ny = out_tdata[100:86];
      a.nz = out_tdata[116:101];
      a.lo = out_tdata[140:117];
      a.hi = out_tdata[164:141];
      a.last = out_tlast;
      if (vertex_q.size() == 0) begin
        errors++;
        $display("%0t unexpected vertex, expected none actual %h", $realtime, out_tdata);
      end else begin
        e = vertex_q.pop_front();
        if (a.wx !== e.wx) report("world_x", e.wx, a.wx);
        if (a.wz !== e.wz) report("world_z", e.wz, a.wz);
        if (a.vh !== e.vh) report("vertex_height", e.vh, a.vh);
        if (a.nx !== e.nx) report("normal_x", e.nx, a.nx);
        if (a.ny !== e.ny) report("normal_y", e.ny, a.ny);
        if (a.nz !== e.nz) report("normal_z", e.nz, a.nz);
        if (a.lo !== e.lo) report("lowest_height", e.lo, a.lo);
        if (a.hi !== e.hi) report("highest_height", e.hi, a.hi);
        if (a.last !== e.last) report("final_vertex", e.last, a.last);
      end
    end
  end

  // called at a rising edge; leaves in_tvalid high so a back-to-back request keeps it
  task automatic send_sample(input logic [IN_W-1:0] h, input bit flush);
    int gap;
    bit rdy;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= h;
    in_tuser <= flush;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    predict_vertex(h, flush);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COLUMNS: reg_cols = val & 16'h07FF;
      CFG_ROWS:    reg_rows = val;
      CFG_STRIDE:  reg_stride = val & 16'h007F;
      CFG_SQUARE:  reg_square = val & 16'h007F;
      CFG_GSCALE:  reg_gscale = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(input int cols, input int rows, input int stride, input int sq,
                          input int gs);
    cfg_write(CFG_COLUMNS, 16'(cols));
    cfg_write(CFG_ROWS, 16'(rows));
    cfg_write(CFG_STRIDE, 16'(stride));
    cfg_write(CFG_SQUARE, 16'(sq));
    cfg_write(CFG_GSCALE, 16'(gs));
  endtask

  function automatic logic [IN_W-1:0] pick_height(input logic [IN_W-1:0] base);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       return r[23:0];
      1:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return base + {{16{r[7]}}, r[7:0]};
    endcase
  endfunction

  // flush tail: columns + 1 drain requests finish the grid
  task automatic flush_tail();
    int cols;
    cols = int'(clampu(reg_cols, 2, COLS_MAX));
    for (int i = 0; i <= cols; i++) send_sample(24'($urandom), 1'b1);
  endtask

  task automatic test_height_extremes();
    logic [IN_W-1:0] hs [4] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
    set_grid(2, 2, 64, 64, 65535);
    foreach (hs[i]) send_sample(hs[i], 1'b0);
    flush_tail();
    drain();
  endtask

  task automatic test_flush_in_grid();
    set_grid(3, 3, 1, 1, 1);
    for (int i = 0; i < 9; i++) send_sample(24'(24'h001000 * i), (i == 4));
    flush_tail();
    drain();
  endtask

  task automatic run_grid(input int flush_rate);
    int cols, rows;
    logic [IN_W-1:0] base;
    cols = int'(clampu(reg_cols, 2, COLS_MAX));
    rows = int'(clampu(reg_rows, 2, 65535));
    base = 24'($urandom);
    for (int i = 0; i < cols * rows; i++) begin
      base = pick_height(base);
      send_sample(base, flush_rate != 0 && $urandom_range(0, flush_rate) == 0);
    end
    flush_tail();
    drain();
  endtask

  task automatic test_clamped_settings();
    // out-of-range raw values are used saturated
    set_grid(1, 0, 0, 127, 4096);
    run_grid(0);
    set_grid(2047, 3, 127, 0, 32768);
    cfg_write(CFG_COLUMNS, 16'd5);
    run_grid(0);
  endtask

  task automatic test_random_grids();
    int gs, start;
    start = sent;
    while (sent - start < 280) begin
      case ($urandom_range(0, 3))
        0:       gs = 1;
        1:       gs = 65535;
        default: gs = $urandom_range(1, 65535);
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      set_grid($urandom_range(2, 8), $urandom_range(2, 6), $urandom_range(1, 64),
               $urandom_range(1, 64), gs);
      run_grid(($urandom_range(0, 1) == 0) ? 0 : 12);
    end
    no_idle = 0;
  endtask

  task automatic test_output_stall();
    set_grid(6, 5, 3, 5, 2000);
    hold_req = 1;
    run_grid(10);
  endtask

  task automatic test_long_row();
    no_idle = 1;
    set_grid(160, 2, 64, 64, 16);
    run_grid(0);
    no_idle = 0;
  endtask

  initial begin
    for (int i = 0; i < COLS_MAX; i++) begin
      prev_row[i] = 0;
      older_row[i] = 0;
    end
    foreach (win[i, j]) win[i][j] = 0;
    col_pos = 0;
    row_pos = 0;
    clear_extremes();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_height_extremes();
    test_flush_in_grid();
    test_clamped_settings();
    test_output_stall();
    test_random_grids();
    test_long_row();
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
